### design/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the double-ended queue.
// Used by double_ended_queue and deq_checker; no dependencies.
package deq_pkg;

    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_INDEX = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

### design/deq_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/double_ended_queue.sv
`timescale 1ns / 1ps
// Double-ended queue of fixed capacity kept in a ring of RAM slots.
// Depends on deq_pkg and deq_ram.
//
// Usage:
//   Request channel: i_in_valid / o_in_ready with i_opcode, i_data_in,
//   i_position. Opcodes: push back, pop back, push front, pop front, read at
//   an index counted from the front.
//   Response channel: o_out_valid / i_out_ready with o_data_out, o_status,
//   o_element_count. Every request gives exactly one response, in order.
//   Pointer and count are updated in the cycle a request is taken, and the
//   RAM access (write for a push, read otherwise) is issued in that cycle.
//   The response passes through the RAM read register and then the output
//   register before it is offered on the response channel.
//   Throughput: one request per cycle while responses are taken; the single-port
//   RAM sees one access per request, and a read is always issued in a later
//   cycle than any earlier write to the same slot, so no forwarding is needed.
//   Refused requests (pop on empty, push on full, index past the count)
//   return zero data with the matching status and leave the state alone.
//   Reset empties the queue; slot contents are not cleared.
//   When the receiver stalls, the response is held and o_in_ready drops
//   once the internal stage behind the output register is occupied.
module double_ended_queue #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [deq_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [deq_pkg::DATA_W-1:0]       i_data_in,
    input  logic [deq_pkg::POS_W-1:0]        i_position,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [deq_pkg::DATA_W-1:0]       o_data_out,
    output logic [deq_pkg::STATUS_W-1:0]     o_status,
    output logic [deq_pkg::COUNT_W-1:0]      o_element_count
);

    import deq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int SUM_W = PTR_W + 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);

    logic [PTR_W-1:0]     r_front, n_front;
    logic [CNT_W-1:0]     r_count, n_count;

    logic                 r_s1_valid;
    logic                 r_s1_read;
    t_status              r_s1_status;
    logic [COUNT_W-1:0]   r_s1_count;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    t_status              r_out_status;
    logic [COUNT_W-1:0]   r_out_count;

    logic                 in_accept;
    logic                 out_free;
    logic                 s1_move;
    logic                 is_full;
    logic                 is_empty;
    logic                 pos_bad;
    logic [PTR_W-1:0]     offset;
    logic [SUM_W-1:0]     ring_sum;
    logic [PTR_W-1:0]     ring_addr;
    logic                 ram_we;
    logic                 ram_re;
    logic [PTR_W-1:0]     ram_addr;
    logic [WORD_BITS-1:0] ram_rdata;
    t_status              req_status;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    assign is_full  = (r_count == CAP_CNT);
    assign is_empty = (r_count == '0);
    assign pos_bad  = (CMP_W'(i_position) >= CMP_W'(r_count));

    // ring offset from the front pointer
    always_comb begin
        case (i_opcode)
            OP_PUSH_BACK:  offset = PTR_W'(r_count);
            OP_POP_BACK:   offset = PTR_W'(r_count - CNT_W'(1));
            OP_PUSH_FRONT: offset = PTR_W'(CAPACITY - 1);
            OP_POP_FRONT:  offset = PTR_W'(1);
            OP_READ_INDEX: offset = PTR_W'(i_position);
            default:       offset = '0;
        endcase
    end

    assign ring_sum  = SUM_W'(r_front) + SUM_W'(offset);
    assign ring_addr = (ring_sum >= CAP_SUM) ? PTR_W'(ring_sum - CAP_SUM) : PTR_W'(ring_sum);

    always_comb begin
        n_front    = r_front;
        n_count    = r_count;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = ring_addr;
        req_status = ST_OK;
        unique case (i_opcode)
            OP_PUSH_BACK: begin
                if (is_full) begin
                    req_status = ST_FULL;
                end else begin
                    ram_we  = in_accept;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    req_status = ST_EMPTY;
                end else begin
                    ram_re  = in_accept;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    req_status = ST_FULL;
                end else begin
                    ram_we  = in_accept;
                    n_front = ring_addr;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                ram_addr = r_front;
                if (is_empty) begin
                    req_status = ST_EMPTY;
                end else begin
                    ram_re  = in_accept;
                    n_front = ring_addr;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_READ_INDEX: begin
                if (pos_bad) begin
                    req_status = ST_RANGE;
                end else begin
                    ram_re = in_accept;
                end
            end
            default: begin
            end
        endcase
    end

    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_deq_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (WORD_BITS'(i_data_in)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_read   <= ram_re;
            r_s1_status <= req_status;
            r_s1_count  <= COUNT_W'(n_count);
        end
        if (s1_move) begin
            r_out_data   <= r_s1_read ? DATA_W'(ram_rdata) : '0;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_out      = r_out_data;
    assign o_status        = r_out_status;
    assign o_element_count = r_out_count;

endmodule

### design/deq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for double_ended_queue, attached by bind.
// Depends on deq_pkg.
module deq_checker #(
    parameter int CAPACITY  = 64
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [deq_pkg::DATA_W-1:0]       o_data_out,
    input logic [deq_pkg::STATUS_W-1:0]     o_status,
    input logic [deq_pkg::COUNT_W-1:0]      o_element_count
);

    import deq_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_OUT = COUNT_W'(CAPACITY);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    a_empty_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_element_count == '0 && o_data_out == '0)
        else $error("empty response with data or nonzero count");

    a_full_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_element_count == CAP_OUT && o_data_out == '0)
        else $error("full response with wrong count or data");

    a_range_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_RANGE |-> o_data_out == '0)
        else $error("range error response carries data");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_out)
            && $stable(o_status) && $stable(o_element_count))
        else $error("stalled response changed");

endmodule

bind double_ended_queue deq_checker #(
    .CAPACITY  (CAPACITY)
) u_deq_checker (.*);

### tb/double_ended_queue_test.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue: directed and random requests are
// compared field by field against an in-bench deque model, with random stalls.
// Depends on deq_pkg and the double_ended_queue RTL.
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int N_ITEMS     = 1700;
    localparam int TAIL_ITEMS  = 200;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_READ} t_phase;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   data;
        logic [POS_W-1:0]    pos;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_rsp;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic [OPCODE_W-1:0] i_opcode        = '0;
    logic [DATA_W-1:0]   i_data_in       = '0;
    logic [POS_W-1:0]    i_position      = '0;
    logic                i_out_ready     = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [DATA_W-1:0]   o_data_out;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_element_count;

    t_req req_q[$];
    t_rsp rsp_q[$];

    logic [DATA_W-1:0]  ring_mem [DEPTH];
    logic [POS_W-1:0]   ring_front = '0;
    logic [COUNT_W-1:0] ring_count = '0;

    int gen_count  = 0;
    int n_accepted = 0;
    int fail_cnt   = 0;
    int cycle_cnt  = 0;
    int send_gap   = 0;
    int recv_stall = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    always #5 i_clk = ~i_clk;

    double_ended_queue u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_data_in      (i_data_in),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_out     (o_data_out),
        .o_status       (o_status),
        .o_element_count(o_element_count)
    );

    // Deque model: applies one request, returns the response it should give.
    function automatic t_rsp apply_request(t_req r);
        t_rsp rsp;
        rsp = '{data: '0, status: ST_OK, count: '0};
        case (r.opcode)
            OP_PUSH_BACK: begin
                if (ring_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    ring_mem[POS_W'(ring_front + ring_count)] = r.data;
                    ring_count++;
                end
            end
            OP_POP_BACK: begin
                if (ring_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.data = ring_mem[POS_W'(ring_front + ring_count - 1)];
                    ring_count--;
                end
            end
            OP_PUSH_FRONT: begin
                if (ring_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    ring_front = ring_front - 1'b1;
                    ring_mem[ring_front] = r.data;
                    ring_count++;
                end
            end
            OP_POP_FRONT: begin
                if (ring_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.data = ring_mem[ring_front];
                    ring_front = ring_front + 1'b1;
                    ring_count--;
                end
            end
            OP_READ_INDEX: begin
                if (COUNT_W'(r.pos) >= ring_count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.data = ring_mem[POS_W'(ring_front + r.pos)];
                end
            end
            default: ;
        endcase
        rsp.count = ring_count;
        return rsp;
    endfunction

    // Queues a request and tracks the element count to steer generation.
    task automatic add_req(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] d,
                           logic [POS_W-1:0] p);
        t_req item;
        item = '{opcode: op, data: d, pos: p};
        req_q.insert(req_q.size(), item);
        if ((op == OP_PUSH_BACK || op == OP_PUSH_FRONT) && gen_count < DEPTH)
            gen_count++;
        else if ((op == OP_POP_BACK || op == OP_POP_FRONT) && gen_count > 0)
            gen_count--;
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0 && gen_count > 0)
            return POS_W'(gen_count - 1);
        else if (r == 1 && gen_count < DEPTH)
            return POS_W'(gen_count);
        else if (r < 8 && gen_count > 0)
            return POS_W'($urandom_range(0, gen_count - 1));
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    initial begin
        int     counted;
        int     phase_left;
        int     r;
        int     push_pct;
        int     pop_pct;
        t_phase phase;

        add_req(OP_POP_BACK, '1, '0);
        add_req(OP_POP_FRONT, '0, '1);
        add_req(OP_READ_INDEX, '0, '0);
        add_req(OP_READ_INDEX, '1, '1);
        add_req(OP_SPARE_LO, 32'h1234_5678, 6'd5);
        add_req(OP_SPARE_HI, '1, '1);
        add_req(OP_PUSH_BACK, '0, '0);
        add_req(OP_PUSH_BACK, '1, '1);
        add_req(OP_PUSH_FRONT, 32'hA5A5_A5A5, 6'd0);
        add_req(OP_PUSH_FRONT, 32'h5A5A_5A5A, 6'd0);
        add_req(OP_READ_INDEX, '0, 6'd0);
        add_req(OP_READ_INDEX, '0, 6'd3);
        add_req(OP_READ_INDEX, '0, 6'd4);
        add_req(OP_READ_INDEX, '0, '1);
        add_req(OP_POP_BACK, '0, '0);
        add_req(OP_POP_FRONT, '0, '0);
        add_req(OP_READ_INDEX, '0, 6'd1);
        add_req(OP_PUSH_BACK, 32'h1234_5678, '1);
        add_req(OP_POP_FRONT, '0, '0);
        add_req(OP_POP_FRONT, '0, '0);
        add_req(OP_POP_BACK, '0, '0);
        add_req(OP_POP_FRONT, '0, '0);

        counted    = req_q.size();
        phase_left = 0;
        phase      = PH_FILL;
        while (counted < N_ITEMS) begin
            if (phase_left == 0) begin
                phase      = t_phase'($urandom_range(0, 3));
                phase_left = $urandom_range(60, 120);
            end
            phase_left--;
            case (phase)
                PH_FILL:  begin push_pct = 75; pop_pct = 10; end
                PH_DRAIN: begin push_pct = 10; pop_pct = 75; end
                PH_MIXED: begin push_pct = 35; pop_pct = 35; end
                default:  begin push_pct = 20; pop_pct = 20; end
            endcase
            r = $urandom_range(0, 99);
            if (r < 4) begin
                add_req(OPCODE_W'(OP_SPARE_LO
                                  + $urandom_range(0, OP_SPARE_HI - OP_SPARE_LO)),
                        $urandom, POS_W'($urandom));
                counted++;
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < push_pct)
                add_req($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                        pick_data(), POS_W'($urandom));
            else if (r < push_pct + pop_pct)
                add_req($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                        $urandom, POS_W'($urandom));
            else
                add_req(OP_READ_INDEX, $urandom, pick_pos());
            counted++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(req_q.size() == 0 && !i_in_valid && rsp_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_cnt == 0 && rsp_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    // Request driver
    always @(posedge i_clk) begin
        logic fire;
        logic nxt_valid;
        t_req r;
        fire      = i_in_valid && o_in_ready;
        nxt_valid = i_in_valid;
        if (i_rst_n) begin
            if (fire) begin
                rsp_q.insert(rsp_q.size(),
                             apply_request('{opcode: i_opcode, data: i_data_in,
                                             pos: i_position}));
                n_accepted++;
            end
            if (!i_in_valid || fire) begin
                nxt_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 15);
                end else if (req_q.size() > 0) begin
                    r          = req_q[0];
                    req_q.delete(0);
                    i_opcode   <= r.opcode;
                    i_data_in  <= r.data;
                    i_position <= r.pos;
                    nxt_valid  = 1'b1;
                end
            end
        end
        i_in_valid <= nxt_valid;
    end

    // Response monitor and receiver stalls
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (rsp_q.size() == 0) begin
                    $display("%0t: unexpected response data %h status %0d count %0d",
                             $realtime, o_data_out, o_status, o_element_count);
                    fail_cnt++;
                end else begin
                    exp_rsp = rsp_q[0];
                    rsp_q.delete(0);
                    if (o_data_out !== exp_rsp.data) begin
                        $display("%0t: data_out expected %h actual %h",
                                 $realtime, exp_rsp.data, o_data_out);
                        fail_cnt++;
                    end
                    if (o_status !== exp_rsp.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_rsp.status, o_status);
                        fail_cnt++;
                    end
                    if (o_element_count !== exp_rsp.count) begin
                        $display("%0t: element_count expected %0d actual %0d",
                                 $realtime, exp_rsp.count, o_element_count);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
                recv_stall = $urandom_range(0, 15);
            end else begin
                rdy = 1'b1;
            end
        end
        i_out_ready <= rdy;
    end

endmodule

### filelist.f
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
design/deq_checker.sv
tb/double_ended_queue_test.sv
